>>> rtl/cpvs_pkg.sv
// ----------------------------------------------------------------------------
// cpvs_pkg
// Types, codes and helper functions shared by the value skipper modules.
// ----------------------------------------------------------------------------
package cpvs_pkg;

  localparam int unsigned DepthLimitW = 7;
  localparam logic [6:0]  DepthLimitReset = 7'd64;
  localparam logic [3:0]  NibbleMask = 4'hF;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_MORE      = 3'd1,
    ST_DONE      = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_e;

  // Compact type codes.
  localparam logic [3:0] TY_STOP   = 4'd0;
  localparam logic [3:0] TY_TRUE   = 4'd1;
  localparam logic [3:0] TY_FALSE  = 4'd2;
  localparam logic [3:0] TY_BYTE   = 4'd3;
  localparam logic [3:0] TY_I16    = 4'd4;
  localparam logic [3:0] TY_I32    = 4'd5;
  localparam logic [3:0] TY_I64    = 4'd6;
  localparam logic [3:0] TY_DOUBLE = 4'd7;
  localparam logic [3:0] TY_BINARY = 4'd8;
  localparam logic [3:0] TY_LIST   = 4'd9;
  localparam logic [3:0] TY_SET    = 4'd10;
  localparam logic [3:0] TY_MAP    = 4'd11;
  localparam logic [3:0] TY_STRUCT = 4'd12;
  localparam logic [3:0] TY_FLOAT  = 4'd13;

  localparam logic [3:0] VarintMaxBytes = 4'd10;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_FHDR  = 4'd1,
    M_FID   = 4'd2,
    M_VINT  = 4'd3,
    M_BLEN  = 4'd4,
    M_SKIP  = 4'd5,
    M_CHDR  = 4'd6,
    M_CCNT  = 4'd7,
    M_MCNT  = 4'd8,
    M_MTYP  = 4'd9,
    M_DONE  = 4'd10,
    M_ERR   = 4'd11,
    M_TRUNC = 4'd12
  } mode_e;

  typedef enum logic [1:0] {
    K_STRUCT = 2'd0,
    K_LIST   = 2'd1,
    K_MAP    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    C_IN   = 2'd0,
    C_POPW = 2'd1,
    C_FIN  = 2'd2
  } ctl_e;

  // One nesting frame: 58 bits.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] prev_id;
    logic [3:0]  t1;
    logic [3:0]  t2;
    logic [30:0] rem;
    logic        on_value;
  } frame_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] bytes;
    logic [6:0]  depth;
  } result_t;

  typedef struct packed {
    mode_e       mode;
    logic        skip_en;
    logic [63:0] skip;
    logic        vrst;
    logic        push;
    kind_e       kind;
    logic        done;
  } sv_res_t;

  function automatic logic is_scanning(mode_e m);
    return (m >= M_FHDR) && (m <= M_MTYP);
  endfunction

  function automatic status_e mode_status(mode_e m);
    status_e s;
    if (m == M_IDLE) begin
      s = ST_IDLE;
    end else if (is_scanning(m)) begin
      s = ST_MORE;
    end else if (m == M_DONE) begin
      s = ST_DONE;
    end else if (m == M_ERR) begin
      s = ST_MALFORMED;
    end else begin
      s = ST_TRUNCATED;
    end
    return s;
  endfunction

  // Effects of starting a value of type t. A bool inside a field header
  // completes at once.
  function automatic sv_res_t start_value(logic [3:0] t, logic hdr);
    sv_res_t r;
    r = '0;
    r.mode = M_ERR;
    r.kind = K_STRUCT;
    case (t)
      TY_TRUE, TY_FALSE: begin
        if (hdr) begin
          r.done = 1'b1;
          r.mode = M_DONE;
        end else begin
          r.mode = M_SKIP; r.skip_en = 1'b1; r.skip = 64'd1;
        end
      end
      TY_BYTE: begin
        r.mode = M_SKIP; r.skip_en = 1'b1; r.skip = 64'd1;
      end
      TY_I16, TY_I32, TY_I64: begin
        r.mode = M_VINT; r.vrst = 1'b1;
      end
      TY_DOUBLE: begin
        r.mode = M_SKIP; r.skip_en = 1'b1; r.skip = 64'd8;
      end
      TY_FLOAT: begin
        r.mode = M_SKIP; r.skip_en = 1'b1; r.skip = 64'd4;
      end
      TY_BINARY: begin
        r.mode = M_BLEN; r.vrst = 1'b1;
      end
      TY_LIST, TY_SET: begin
        r.mode = M_CHDR; r.push = 1'b1; r.kind = K_LIST;
      end
      TY_MAP: begin
        r.mode = M_MCNT; r.push = 1'b1; r.kind = K_MAP; r.vrst = 1'b1;
      end
      TY_STRUCT: begin
        r.mode = M_FHDR; r.push = 1'b1; r.kind = K_STRUCT;
      end
      default: r.mode = M_ERR;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/cpvs_frame_mem.sv
// ----------------------------------------------------------------------------
// cpvs_frame_mem
// Frame stack storage: one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module cpvs_frame_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  cpvs_pkg::frame_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_i,
  output cpvs_pkg::frame_t rdata_o
);
  import cpvs_pkg::*;

  frame_t mem_q [DEPTH];
  frame_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cpvs_core.sv
// ----------------------------------------------------------------------------
// cpvs_core
// Scan engine: top frame in a register, frames below it in the frame memory.
// ----------------------------------------------------------------------------
module cpvs_core #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [1:0]        operation_i,
  input  logic [3:0]        value_type_i,
  input  logic [7:0]        data_byte_i,
  input  logic [6:0]        depth_limit_i,
  output logic              ready_o,
  output logic              result_valid_o,
  output cpvs_pkg::result_t result_o
);
  import cpvs_pkg::*;

  localparam int unsigned SPW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  ctl_e        ctl_q, ctl_d;
  mode_e       mode_q, mode_d;
  logic [SPW-1:0] sp_q, sp_d;
  frame_t      top_q, top_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  vidx_q, vidx_d;
  logic [63:0] skip_q, skip_d;
  logic [3:0]  pend_q, pend_d;
  logic [31:0] cnt_q, cnt_d;

  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  frame_t      mem_wdata;
  frame_t      mem_rdata;

  logic        go_pop, go_fin, active, sv_go, sv_hdr;
  logic [3:0]  sv_t;
  sv_res_t     sv;

  // Varint feed of the incoming byte.
  logic [6:0]  v_sh;
  logic [63:0] v_acc;
  logic [3:0]  v_idx;
  logic        v_comp, v_err;
  logic [16:0] id_sum;
  logic [63:0] skip_dec;
  logic [30:0] rem_dec;

  always_comb begin
    v_sh  = 7'(vidx_q) * 7'd7;
    v_acc = acc_q;
    if (v_sh < 7'd64) begin
      v_acc = acc_q | ({57'd0, data_byte_i[6:0]} << v_sh[5:0]);
    end
    v_idx  = vidx_q + 4'd1;
    v_comp = !data_byte_i[7];
    v_err  = data_byte_i[7] && (v_idx >= VarintMaxBytes);
  end

  assign id_sum   = {top_q.prev_id[15], top_q.prev_id} + {13'd0, data_byte_i[7:4]};
  assign skip_dec = (skip_q != 64'd0) ? skip_q - 64'd1 : skip_q;
  assign rem_dec  = (top_q.rem != 31'd0) ? top_q.rem - 31'd1 : top_q.rem;

  always_comb begin
    mode_d = mode_q;
    sp_d   = sp_q;
    top_d  = top_q;
    acc_d  = acc_q;
    vidx_d = vidx_q;
    skip_d = skip_q;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    go_pop = 1'b0;
    go_fin = 1'b0;
    sv_go  = 1'b0;
    sv_hdr = 1'b0;
    sv_t   = TY_STOP;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = top_q;
    mem_re = 1'b0;
    mem_raddr = '0;
    active = 1'b0;
    sv = '0;

    unique case (ctl_q)
      C_IN: begin
        if (fire_i) begin
          active = 1'b1;
          unique case (op_e'(operation_i))
            OP_BEGIN: begin
              sp_d = '0; acc_d = '0; vidx_d = '0; skip_d = '0; pend_d = '0;
              cnt_d = '0;
              sv_go = 1'b1; sv_t = value_type_i; sv_hdr = 1'b1;
            end
            OP_BYTE: begin
              if (is_scanning(mode_q)) begin
                if (cnt_q != 32'hFFFF_FFFF) begin
                  cnt_d = cnt_q + 32'd1;
                end
                unique case (mode_q)
                  M_FHDR: begin
                    if (data_byte_i == 8'd0) begin
                      go_pop = 1'b1;
                    end else if (data_byte_i[7:4] != 4'd0) begin
                      if (data_byte_i[3:0] == TY_STOP || (!id_sum[16] && id_sum[15])) begin
                        mode_d = M_ERR;
                      end else begin
                        top_d.prev_id = id_sum[15:0];
                        sv_go = 1'b1; sv_t = data_byte_i[3:0]; sv_hdr = 1'b1;
                      end
                    end else begin
                      pend_d = data_byte_i[3:0];
                      acc_d = '0; vidx_d = '0;
                      mode_d = M_FID;
                    end
                  end
                  M_FID: begin
                    acc_d = v_acc; vidx_d = v_idx;
                    if (v_err) begin
                      mode_d = M_ERR;
                    end else if (v_comp) begin
                      if (v_acc > 64'h0000_0000_0000_FFFF) begin
                        mode_d = M_ERR;
                      end else begin
                        top_d.prev_id = v_acc[0] ? ~{1'b0, v_acc[15:1]}
                                                 : {1'b0, v_acc[15:1]};
                        sv_go = 1'b1; sv_t = pend_q; sv_hdr = 1'b1;
                      end
                    end
                  end
                  M_VINT: begin
                    acc_d = v_acc; vidx_d = v_idx;
                    if (v_err) begin
                      mode_d = M_ERR;
                    end else if (v_comp) begin
                      go_fin = 1'b1;
                    end
                  end
                  M_BLEN: begin
                    acc_d = v_acc; vidx_d = v_idx;
                    if (v_err) begin
                      mode_d = M_ERR;
                    end else if (v_comp) begin
                      if (v_acc == 64'd0) begin
                        go_fin = 1'b1;
                      end else begin
                        skip_d = v_acc;
                        mode_d = M_SKIP;
                      end
                    end
                  end
                  M_SKIP: begin
                    skip_d = skip_dec;
                    if (skip_dec == 64'd0) begin
                      go_fin = 1'b1;
                    end
                  end
                  M_CHDR: begin
                    top_d.t1 = data_byte_i[3:0];
                    if (data_byte_i[7:4] == NibbleMask) begin
                      acc_d = '0; vidx_d = '0;
                      mode_d = M_CCNT;
                    end else if (data_byte_i[7:4] == 4'd0) begin
                      go_pop = 1'b1;
                    end else begin
                      top_d.rem = {27'd0, data_byte_i[7:4]};
                      sv_go = 1'b1; sv_t = data_byte_i[3:0];
                    end
                  end
                  M_CCNT, M_MCNT: begin
                    acc_d = v_acc; vidx_d = v_idx;
                    if (v_err || (v_comp && v_acc > 64'h0000_0000_7FFF_FFFF)) begin
                      mode_d = M_ERR;
                    end else if (v_comp) begin
                      if (v_acc == 64'd0) begin
                        go_pop = 1'b1;
                      end else begin
                        top_d.rem = v_acc[30:0];
                        if (mode_q == M_CCNT) begin
                          sv_go = 1'b1; sv_t = top_q.t1;
                        end else begin
                          mode_d = M_MTYP;
                        end
                      end
                    end
                  end
                  M_MTYP: begin
                    top_d.t1 = data_byte_i[7:4];
                    top_d.t2 = data_byte_i[3:0];
                    top_d.on_value = 1'b0;
                    sv_go = 1'b1; sv_t = data_byte_i[7:4];
                  end
                  default: ;
                endcase
              end
            end
            OP_END: begin
              if (is_scanning(mode_q)) begin
                mode_d = M_TRUNC;
              end
            end
            default: ;
          endcase
        end
      end
      C_POPW: begin
        top_d = mem_rdata;
      end
      C_FIN: begin
        active = 1'b1;
        if (sp_q == '0) begin
          mode_d = M_DONE;
        end else if (top_q.kind == K_STRUCT) begin
          mode_d = M_FHDR;
        end else if (top_q.kind == K_MAP && !top_q.on_value) begin
          top_d.on_value = 1'b1;
          sv_go = 1'b1; sv_t = top_q.t2;
        end else begin
          top_d.rem = rem_dec;
          if (rem_dec == 31'd0) begin
            go_pop = 1'b1;
          end else begin
            top_d.on_value = 1'b0;
            sv_go = 1'b1; sv_t = top_q.t1;
          end
        end
      end
      default: ;
    endcase

    // Start of a new value, pushing a frame for containers. The frame that
    // goes to memory carries the updates made by this same beat.
    if (sv_go) begin
      sv = start_value(sv_t, sv_hdr);
      mode_d = sv.mode;
      if (sv.skip_en) begin
        skip_d = sv.skip;
      end
      if (sv.vrst) begin
        acc_d = '0; vidx_d = '0;
      end
      if (sv.push) begin
        if ((sp_d < SPW'(MAX_DEPTH)) && (32'(sp_d) < 32'(depth_limit_i))) begin
          if (sp_d != '0) begin
            mem_we = 1'b1;
            mem_waddr = AW'(sp_d - SPW'(1));
            mem_wdata = top_d;
          end
          top_d = '0;
          top_d.kind = sv.kind;
          sp_d = sp_d + SPW'(1);
        end else begin
          mode_d = M_ERR;
        end
      end
      if (sv.done) begin
        go_fin = 1'b1;
      end
    end

    // Pop: the new top comes back from memory through its registered read port.
    if (go_pop) begin
      sp_d = sp_d - SPW'(1);
      if (sp_d != '0) begin
        mem_re = 1'b1;
        mem_raddr = AW'(sp_d - SPW'(1));
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      C_IN, C_FIN: begin
        if (active) begin
          if (mem_re) begin
            ctl_d = C_POPW;
          end else if (go_pop || go_fin) begin
            ctl_d = C_FIN;
          end else begin
            ctl_d = C_IN;
          end
        end
      end
      C_POPW: ctl_d = C_FIN;
      default: ctl_d = C_IN;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ready_o        = (ctl_q == C_IN);
    result_valid_o = active && !go_pop && !go_fin;
    result_o.status = mode_status(mode_d);
    result_o.bytes  = cnt_d;
    result_o.depth  = 7'(sp_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= C_IN;
      mode_q <= M_IDLE;
      sp_q   <= '0;
      acc_q  <= '0;
      vidx_q <= '0;
      skip_q <= '0;
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      ctl_q  <= ctl_d;
      mode_q <= mode_d;
      sp_q   <= sp_d;
      acc_q  <= acc_d;
      vidx_q <= vidx_d;
      skip_q <= skip_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  cpvs_frame_mem #(
    .DEPTH(MAX_DEPTH),
    .AW   (AW)
  ) u_frame_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

>>> rtl/compact_protocol_value_skipper.sv
// ----------------------------------------------------------------------------
// compact_protocol_value_skipper
// Skips one compact-protocol value from a byte stream, tracking nesting.
// ----------------------------------------------------------------------------
// A result is registered in the output register. A beat whose value ends
// goes through the finish state first, and a frame that closes waits for
// the frame below it to be read back from the frame memory (unless outermost).
// Throughput: one beat per cycle while no value ends and the output is free.
// Reset: scan mode idle, no frames open, byte count zero, depth limit 64.
module compact_protocol_value_skipper #(
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  value_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] bytes_consumed_o,
  output logic [6:0]  nesting_depth_o
);
  import cpvs_pkg::*;

  logic [6:0] depth_limit_q;
  logic       core_ready, core_valid, out_free, in_fire;
  result_t    core_res, res_q;
  logic       out_valid_q, out_valid_d;

  // Write the depth limit register only while the block is idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_limit_q <= DepthLimitReset;
    end else if (cfg_we_i) begin
      depth_limit_q <= cfg_wdata_i;
    end
  end

  // A new beat is taken only when the sequencer waits for input and the
  // output register is empty or being emptied in this cycle. The result of a
  // beat that needs frames to be closed is produced later, when the output
  // register is known to be empty.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !(core_ready && out_free);
  assign in_fire    = in_valid_i && !in_stall_o;

  cpvs_core #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (in_fire),
    .operation_i   (operation_i),
    .value_type_i  (value_type_i),
    .data_byte_i   (data_byte_i),
    .depth_limit_i (depth_limit_q),
    .ready_o       (core_ready),
    .result_valid_o(core_valid),
    .result_o      (core_res)
  );

  // Output register holding one result beat.
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (core_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid) begin
      res_q <= core_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign bytes_consumed_o = res_q.bytes;
  assign nesting_depth_o  = res_q.depth;

endmodule
